// ----- src/gyro_turn_angle_integrator_unit_assert.svh -----
// Assertion macros for the checker file of this block.
// Both macros expect signals named clk and arst_n in the calling scope.
`ifndef GYRO_TURN_ANGLE_INTEGRATOR_UNIT_ASSERT_SVH
`define GYRO_TURN_ANGLE_INTEGRATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GTI_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define GTI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/gti_pkg.sv -----
package gti_pkg;

	// Field widths.
	localparam int RawW    = 16;
	localparam int TickW   = 32;
	localparam int TargetW = 10;
	localparam int GainW   = 16;
	localparam int DbandW  = 16;
	localparam int CntW    = 8;

	// Internal datapath widths.
	localparam int CalSumW = 32;
	localparam int DivW    = CalSumW + 8;
	localparam int OffsetW = 24;
	localparam int DiffW   = 25;
	localparam int RmulW   = 26;
	localparam int RateW   = 21;
	localparam int SumW    = 22;
	localparam int AmulW   = 24;
	localparam int ProdW   = SumW + TickW;
	localparam int AngleW  = 64;
	localparam int ThrW    = 29;

	// Configuration port.
	localparam int PaddrW = 3;
	localparam int PdataW = 32;

	typedef enum logic [0:0] {
		REG_RATE_GAIN = 1'b0,
		REG_DEADBAND  = 1'b1
	} reg_idx_t;

	localparam logic [GainW-1:0]  GAIN_RESET  = 16'd3996;
	localparam logic [DbandW-1:0] DBAND_RESET = 16'd128;

	localparam logic signed [RateW-1:0]  RATE_MAX  = {1'b0, {(RateW-1){1'b1}}};
	localparam logic signed [RateW-1:0]  RATE_MIN  = {1'b1, {(RateW-1){1'b0}}};
	localparam logic signed [AngleW-1:0] ANGLE_MAX = {1'b0, {(AngleW-1){1'b1}}};
	localparam logic signed [AngleW-1:0] ANGLE_MIN = {1'b1, {(AngleW-1){1'b0}}};

endpackage

// ----- src/gti_sample_if.sv -----
interface gti_sample_if
	import gti_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic signed [RawW-1:0]    gyro_raw;
	logic [TickW-1:0]          tick_ms;
	logic signed [TargetW-1:0] target_deg;

	modport source (output valid, kind, gyro_raw, tick_ms, target_deg, input ready);
	modport sink (input valid, kind, gyro_raw, tick_ms, target_deg, output ready);
endinterface

// ----- src/gti_result_if.sv -----
interface gti_result_if
	import gti_pkg::*;
();
	logic valid;
	logic ready;
	logic reached;
	logic tracking;
	logic calibrated;

	modport source (output valid, reached, tracking, calibrated, input ready);
	modport sink (input valid, reached, tracking, calibrated, output ready);
endinterface

// ----- src/gyro_turn_angle_integrator_unit.sv -----
// Channel   Direction  Handshake      Payload
// sample    in         valid/ready    kind, gyro_raw, tick_ms, target_deg
// result    out        valid/ready    reached, tracking, calibrated
// apb       in         psel/penable   rate_gain_q16 at 0x0, deadband_q8 at 0x4
//
// One item is in work at a time; sample.ready is high only in the idle state.
// A completed calibration run also steps through the bit-serial divider, and a
// turn item with elapsed time through the rate multiplier (16 gain bits) and
// the angle multiplier (32 time bits).
// The result register lets a new item in while the last result waits to be taken.
// arst_n clears all turn and calibration state and loads the register defaults.
module gyro_turn_angle_integrator_unit
	import gti_pkg::*;
#(
	parameter int CAL_SAMPLES = 200
) (
	input  logic               clk,
	input  logic               arst_n,
	gti_sample_if.sink         sample,
	gti_result_if.source       result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PaddrW-1:0]  paddr,
	input  logic [PdataW-1:0]  pwdata,
	output logic [PdataW-1:0]  prdata,
	output logic               pready
);

	localparam int CalW = $clog2(CAL_SAMPLES + 1);
	localparam int CntBits = $clog2(DivW);
	localparam logic [CntW-1:0] CalCnt = CntW'(CAL_SAMPLES);
	localparam logic [CalW:0] CalDiv = (CalW + 1)'(CAL_SAMPLES);
	localparam int AccW = AngleW + 1;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_DIV  = 9'b000000010,
		ST_MULR = 9'b000000100,
		ST_RSAT = 9'b000001000,
		ST_SUMS = 9'b000010000,
		ST_MULA = 9'b000100000,
		ST_ACC  = 9'b001000000,
		ST_CMP  = 9'b010000000,
		ST_DONE = 9'b100000000
	} state_t;

	state_t state_q;

	logic [GainW-1:0]          gain_q;
	logic [DbandW-1:0]         dband_q;
	logic                      tracking_q;
	logic signed [AngleW-1:0]  angle_q;
	logic [TickW-1:0]          prev_tick_q;
	logic signed [RateW-1:0]   prev_rate_q;
	logic signed [OffsetW-1:0] offset_q;
	logic signed [CalSumW-1:0] cal_sum_q;
	logic [CntW-1:0]           cal_cnt_q;
	logic [CntBits-1:0]        cnt_q;
	logic                      out_valid_q;

	logic [DivW-1:0]           quo_q;
	logic [CalW-1:0]           rem_q;
	logic                      div_neg_q;
	logic signed [DiffW-1:0]   diff_q;
	logic [GainW-1:0]          gsh_q;
	logic signed [RmulW-1:0]   racc_q;
	logic signed [RateW-1:0]   rate_q;
	logic signed [SumW-1:0]    s_q;
	logic [TickW-1:0]          dt_q;
	logic signed [AmulW-1:0]   ahi_q;
	logic [TickW-1:0]          alo_q;
	logic signed [ThrW-1:0]    thr_q;
	logic                      tgt_neg_q;
	logic                      r_reached_q;
	logic                      r_calib_q;
	logic                      out_reached_q;
	logic                      out_tracking_q;
	logic                      out_calib_q;

	logic                      accept;
	logic                      load_out;
	logic                      cfg_wr;
	logic                      last_step;

	logic signed [CalSumW-1:0] cal_sum_nx;
	logic [CntW-1:0]           cal_cnt_nx;
	logic                      cal_done;
	logic [CalSumW-1:0]        cal_mag;
	logic [TickW-1:0]          dt;
	logic signed [DiffW-1:0]   diff;
	logic signed [ThrW-1:0]    tgt_x;
	logic signed [ThrW-1:0]    thr;

	logic [CalW:0]             rem2;
	logic [CalW:0]             rem_sub;
	logic                      div_ge;
	logic [CalW-1:0]           rem_nx;
	logic [DivW-1:0]           quo_nx;
	logic [OffsetW-1:0]        off_mag;
	logic [OffsetW-1:0]        off_nx;

	logic signed [RmulW-1:0]   r_addend;
	logic signed [RmulW-1:0]   r_sum;
	logic signed [RateW-1:0]   rate_sat;
	logic signed [SumW-1:0]    rate_neg;
	logic [RateW-1:0]          rate_mag;
	logic signed [RateW-1:0]   rate_fin;

	logic signed [AmulW-1:0]   a_addend;
	logic signed [AmulW-1:0]   a_sum;
	logic signed [ProdW-1:0]   prod;
	logic signed [AccW-1:0]    asum;
	logic signed [AngleW-1:0]  angle_nx;
	logic signed [AngleW-1:0]  thr_ext;
	logic                      hit;

	assign sample.ready = (state_q == ST_IDLE);
	assign accept = sample.valid && sample.ready;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || result.ready);
	assign last_step = (cnt_q == '0);

	assign result.valid = out_valid_q;
	assign result.reached = out_reached_q;
	assign result.tracking = out_tracking_q;
	assign result.calibrated = out_calib_q;

	// Configuration port: zero wait states, the low address bits are ignored.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (reg_idx_t'(paddr[2])) 
			REG_RATE_GAIN: prdata = PdataW'(gain_q);
			REG_DEADBAND:  prdata = PdataW'(dband_q);
			default:       prdata = '0;
		endcase
	end

	// Decode of the incoming item.
	always_comb begin
		cal_sum_nx = cal_sum_q + CalSumW'(sample.gyro_raw);
		cal_cnt_nx = cal_cnt_q + CntW'(1);
		cal_done = (cal_cnt_nx >= CalCnt);
		cal_mag = cal_sum_nx[CalSumW-1] ? CalSumW'(-cal_sum_nx) : CalSumW'(cal_sum_nx);
		dt = sample.tick_ms - prev_tick_q;
		diff = (DiffW'(sample.gyro_raw) <<< 8) - DiffW'(offset_q);
		// target * 512000 = (target * 125) << 12
		tgt_x = ThrW'(sample.target_deg);
		thr = ((tgt_x <<< 7) - (tgt_x <<< 2) + tgt_x) <<< 12;
	end

	// Restoring division of the calibration sum by the sample count, one
	// quotient bit per cycle, MSB first.
	always_comb begin
		rem2 = {rem_q, quo_q[DivW-1]};
		rem_sub = rem2 - CalDiv;
		div_ge = (rem2 >= CalDiv);
		rem_nx = div_ge ? rem_sub[CalW-1:0] : rem2[CalW-1:0];
		quo_nx = {quo_q[DivW-2:0], div_ge};
		off_mag = quo_nx[OffsetW-1:0];
		off_nx = div_neg_q ? (~off_mag + OffsetW'(1)) : off_mag;
	end

	// Rate multiplier: one gain bit per cycle, LSB first. The dropped low bits
	// make the final accumulator equal to the product shifted down by 16, floored.
	always_comb begin
		r_addend = gsh_q[0] ? RmulW'(diff_q) : RmulW'(0);
		r_sum = racc_q + r_addend;
	end

	always_comb begin
		if (racc_q > RmulW'(RATE_MAX)) begin
			rate_sat = RATE_MAX;
		end else if (racc_q < RmulW'(RATE_MIN)) begin
			rate_sat = RATE_MIN;
		end else begin
			rate_sat = racc_q[RateW-1:0];
		end
		rate_neg = -SumW'(rate_sat);
		rate_mag = rate_sat[RateW-1] ? rate_neg[RateW-1:0] : rate_sat;
		rate_fin = (rate_mag < RateW'(dband_q)) ? RateW'(0) : rate_sat;
	end

	// Angle multiplier: one bit of the elapsed time per cycle, low product
	// bits shift into alo_q.
	always_comb begin
		a_addend = dt_q[0] ? AmulW'(s_q) : AmulW'(0);
		a_sum = ahi_q + a_addend;
		prod = {ahi_q[SumW-1:0], alo_q};
		asum = AccW'(angle_q) + AccW'(prod);
		if (asum[AccW-1] != asum[AccW-2]) begin
			angle_nx = asum[AccW-1] ? ANGLE_MIN : ANGLE_MAX;
		end else begin
			angle_nx = asum[AngleW-1:0];
		end
		thr_ext = AngleW'(thr_q);
		hit = tgt_neg_q ? (angle_q <= thr_ext) : (angle_q >= thr_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gain_q <= GAIN_RESET;
			dband_q <= DBAND_RESET;
			tracking_q <= 1'b0;
			angle_q <= '0;
			prev_tick_q <= '0;
			prev_rate_q <= '0;
			offset_q <= '0;
			cal_sum_q <= '0;
			cal_cnt_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (reg_idx_t'(paddr[2]))
					REG_RATE_GAIN: gain_q <= pwdata[GainW-1:0];
					REG_DEADBAND:  dband_q <= pwdata[DbandW-1:0];
					default: ;
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!sample.kind) begin
							if (cal_done) begin
								cal_sum_q <= '0;
								cal_cnt_q <= '0;
								cnt_q <= CntBits'(DivW - 1);
								state_q <= ST_DIV;
							end else begin
								cal_sum_q <= cal_sum_nx;
								cal_cnt_q <= cal_cnt_nx;
								state_q <= ST_DONE;
							end
						end else if (sample.target_deg == '0) begin
							state_q <= ST_DONE;
						end else if (!tracking_q) begin
							tracking_q <= 1'b1;
							angle_q <= '0;
							prev_tick_q <= sample.tick_ms;
							state_q <= ST_DONE;
						end else begin
							prev_tick_q <= sample.tick_ms;
							if (dt != '0) begin
								cnt_q <= CntBits'(GainW - 1);
								state_q <= ST_MULR;
							end else begin
								state_q <= ST_CMP;
							end
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - CntBits'(1);
					if (last_step) begin
						offset_q <= off_nx;
						state_q <= ST_DONE;
					end
				end
				ST_MULR: begin
					cnt_q <= cnt_q - CntBits'(1);
					if (last_step) begin
						state_q <= ST_RSAT;
					end
				end
				ST_RSAT: begin
					state_q <= ST_SUMS;
				end
				ST_SUMS: begin
					prev_rate_q <= rate_q;
					cnt_q <= CntBits'(TickW - 1);
					state_q <= ST_MULA;
				end
				ST_MULA: begin
					cnt_q <= cnt_q - CntBits'(1);
					if (last_step) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					angle_q <= angle_nx;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (hit) begin
						tracking_q <= 1'b0;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_reached_q <= r_reached_q;
			out_tracking_q <= tracking_q;
			out_calib_q <= r_calib_q;
		end

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					r_reached_q <= sample.kind && (sample.target_deg == '0);
					r_calib_q <= 1'b0;
					quo_q <= {cal_mag, 8'b0};
					rem_q <= '0;
					div_neg_q <= cal_sum_nx[CalSumW-1];
					diff_q <= diff;
					gsh_q <= gain_q;
					racc_q <= '0;
					dt_q <= dt;
					thr_q <= thr;
					tgt_neg_q <= sample.target_deg[TargetW-1];
				end
			end
			ST_DIV: begin
				quo_q <= quo_nx;
				rem_q <= rem_nx;
				if (last_step) begin
					r_calib_q <= 1'b1;
				end
			end
			ST_MULR: begin
				racc_q <= r_sum >>> 1;
				gsh_q <= gsh_q >> 1;
			end
			ST_RSAT: begin
				rate_q <= rate_fin;
			end
			ST_SUMS: begin
				s_q <= SumW'(prev_rate_q) + SumW'(rate_q);
				ahi_q <= '0;
			end
			ST_MULA: begin
				ahi_q <= a_sum >>> 1;
				alo_q <= {a_sum[0], alo_q[TickW-1:1]};
				dt_q <= dt_q >> 1;
			end
			ST_CMP: begin
				r_reached_q <= hit;
			end
			default: ;
		endcase
	end

endmodule

// ----- src/gti_checker.sv -----
module gti_checker (
	input logic clk,
	input logic arst_n,
	input logic smp_valid,
	input logic smp_ready,
	input logic res_valid,
	input logic res_ready,
	input logic res_reached,
	input logic res_tracking,
	input logic res_calib
);

	`include "gyro_turn_angle_integrator_unit_assert.svh"

	// A stalled result keeps its payload.
	`GTI_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_reached) && $stable(res_tracking) && $stable(res_calib), "result changed while stalled")

	// A calibration item never reports a reached target.
	`GTI_ASSERT_IMP(a_cal_no_reach, res_valid && res_calib, !res_reached, "calibrated item reports reached")

	// The block works on one item at a time.
	`GTI_ASSERT_NEXT(a_one_item, smp_valid && smp_ready, !smp_ready, "second item taken during work")

endmodule

bind gyro_turn_angle_integrator_unit gti_checker u_gti_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.smp_valid    (sample.valid),
	.smp_ready    (sample.ready),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.res_reached  (result.reached),
	.res_tracking (result.tracking),
	.res_calib    (result.calibrated)
);
